// ===== hdl/terrain_local_variance_classifier_defines.svh =====
// Assertion macros for the terrain variance classifier top level.
`ifndef TERRAIN_LOCAL_VARIANCE_CLASSIFIER_DEFINES_SVH
`define TERRAIN_LOCAL_VARIANCE_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and held off during rst.
`define TLVC_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tlvc assertion failed");
// Next-cycle implication, sampled on clk and held off during rst.
`define TLVC_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tlvc assertion failed");
`else
`define TLVC_ASSERT_NOW(lbl, cond, prop)
`define TLVC_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ===== hdl/tlvc_pkg.sv =====
// Types, constants and codes shared by the terrain variance classifier.
`default_nettype none
package tlvc_pkg;

  // Store geometry and sample width.
  localparam int MAX_SIDE    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int COORD_BITS  = $clog2(MAX_SIDE);
  localparam int ADDR_BITS   = 2 * COORD_BITS;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;

  // Field widths fixed by the interface.
  localparam int POS_BITS      = 8;
  localparam int HEIGHT_BITS   = 16;
  localparam int MAP_SIDE_BITS = 9;
  localparam int LIMIT_BITS    = 32;
  localparam int VAR_BITS      = 32;

  // Signed width that holds a window coordinate before clamping.
  localparam int SIDE_BITS = $clog2(MAX_SIDE + 1);
  localparam int CALC_BITS = ((SIDE_BITS > MAP_SIDE_BITS) ? SIDE_BITS : MAP_SIDE_BITS) + 2;

  // Window walk: offsets run from minus radius to plus radius.
  localparam int WIN_RADIUS = 2;
  localparam int WIN_LAST   = 2 * WIN_RADIUS;
  localparam int WIN_BITS   = $clog2(WIN_LAST + 1);

  // Sum of up to 25 squared differences.
  localparam int SUM_BITS = 2 * SAMPLE_BITS + 5;

  // Divide by 24, four quotient bits per step.
  localparam int VAR_DIVISOR = 24;
  localparam int REM_BITS    = 5;
  localparam int DIGIT_BITS  = 4;
  localparam int DIV_STEPS   = (SUM_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DIV_BITS    = DIV_STEPS * DIGIT_BITS;
  localparam int STEP_BITS   = $clog2(DIV_STEPS + 1);

  // Configuration port.
  localparam int REG_COUNT  = 3;
  localparam int PADDR_BITS = $clog2(4 * REG_COUNT);
  localparam int PDATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_MAP_SIDE     = 2'd0,
    REG_SMOOTH_LIMIT = 2'd1,
    REG_ROUGH_LIMIT  = 2'd2
  } reg_index_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CLASS_SMOOTH = 2'd0,
    CLASS_ROUGH  = 2'd1,
    CLASS_SHARP  = 2'd2
  } terrain_class_t;

  typedef struct packed {
    action_t                  action;
    logic [POS_BITS-1:0]      pos_x;
    logic [POS_BITS-1:0]      pos_y;
    logic [HEIGHT_BITS-1:0]   height_value;
  } request_t;

  typedef struct packed {
    terrain_class_t           terrain_class;
    logic [VAR_BITS-1:0]      variance;
  } result_t;

  // Control from the sequencer to the square-accumulate unit.
  typedef struct packed {
    logic clear;
    logic take;
  } acc_ctl_t;

  // Status of the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== hdl/tlvc_store.sv =====
// Single-port height sample store with registered read data.
`default_nettype none
module tlvc_store (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              we,
  input  logic [tlvc_pkg::ADDR_BITS-1:0]    addr,
  input  logic [tlvc_pkg::SAMPLE_BITS-1:0]  wdata,
  output logic [tlvc_pkg::SAMPLE_BITS-1:0]  rdata
);

  logic [tlvc_pkg::SAMPLE_BITS-1:0] mem [tlvc_pkg::STORE_DEPTH];

  // One access per cycle: a write or a registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tlvc_sqacc.sv =====
// Shared difference, square and accumulate unit for the window walk.
`default_nettype none
module tlvc_sqacc (
  input  logic                              clk,
  input  logic                              rst,
  input  tlvc_pkg::acc_ctl_t                ctl,
  input  logic [tlvc_pkg::SAMPLE_BITS-1:0]  ref_height,
  input  logic [tlvc_pkg::SAMPLE_BITS-1:0]  sample,
  output logic [tlvc_pkg::SUM_BITS-1:0]     sum
);

  logic [tlvc_pkg::SAMPLE_BITS-1:0]   diff;
  logic [2*tlvc_pkg::SAMPLE_BITS-1:0] square;
  logic                               diff_valid;
  logic                               square_valid;

  // Valid bits follow each sample through the two stages.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      diff_valid   <= 1'b0;
      square_valid <= 1'b0;
    end else begin
      diff_valid   <= ctl.take;
      square_valid <= diff_valid;
    end
  end

  // Absolute difference, then its square, one register apart.
  always_ff @(posedge clk) begin
    diff   <= (ref_height >= sample) ? (ref_height - sample) : (sample - ref_height);
    square <= diff * diff;
  end

  // Running sum, cleared when a query is taken.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sum <= '0;
    end else if (square_valid) begin
      sum <= sum + tlvc_pkg::SUM_BITS'(square);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tlvc_div24.sv =====
// Iterative divider by 24, several quotient bits per cycle.
`default_nettype none
module tlvc_div24 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [tlvc_pkg::SUM_BITS-1:0]     dividend,
  output tlvc_pkg::div_stat_t               stat,
  output logic [tlvc_pkg::DIV_BITS-1:0]     quotient,
  output logic [tlvc_pkg::REM_BITS-1:0]     remainder
);

  logic [tlvc_pkg::DIV_BITS-1:0]   work;
  logic [tlvc_pkg::REM_BITS-1:0]   rem;
  logic [tlvc_pkg::STEP_BITS-1:0]  count;
  logic                            done;
  logic [tlvc_pkg::DIV_BITS-1:0]   work_next;
  logic [tlvc_pkg::REM_BITS-1:0]   rem_next;
  logic [tlvc_pkg::REM_BITS:0]     trial;

  // Restoring steps: shift a dividend bit into the remainder, subtract
  // the divisor where it fits and shift the quotient bit into the word.
  always_comb begin
    work_next = work;
    rem_next  = rem;
    trial     = '0;
    for (int i = 0; i < tlvc_pkg::DIGIT_BITS; i++) begin
      trial     = {rem_next, work_next[tlvc_pkg::DIV_BITS-1]};
      work_next = {work_next[tlvc_pkg::DIV_BITS-2:0], 1'b0};
      if (trial >= (tlvc_pkg::REM_BITS + 1)'(tlvc_pkg::VAR_DIVISOR)) begin
        trial        = trial - (tlvc_pkg::REM_BITS + 1)'(tlvc_pkg::VAR_DIVISOR);
        work_next[0] = 1'b1;
      end
      rem_next = trial[tlvc_pkg::REM_BITS-1:0];
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= tlvc_pkg::STEP_BITS'(tlvc_pkg::DIV_STEPS);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      if (count == tlvc_pkg::STEP_BITS'(1)) begin
        done <= 1'b1;
      end
    end
  end

  // Working word and partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= tlvc_pkg::DIV_BITS'(dividend);
      rem  <= '0;
    end else if (count != '0) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign stat.busy = (count != '0);
  assign stat.done = done;
  assign quotient  = work;
  assign remainder = rem;

endmodule
`default_nettype wire

// ===== hdl/terrain_local_variance_classifier.sv =====
// Write request: accepted while idle, stored at once, gives no result.
// Query request: the walk makes 25 store reads, the square-accumulate pipeline
// drains, the divider runs, the result register loads, and the sequencer
// returns to idle before the next request is taken.
// Synchronous reset clears the sequencer and handshakes and loads the register
// defaults; the height store keeps its contents and is undefined until written.
`default_nettype none
`include "terrain_local_variance_classifier_defines.svh"
module terrain_local_variance_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              request_valid,
  output logic                              request_stall,
  input  tlvc_pkg::request_t                request,
  output logic                              result_valid,
  input  logic                              result_stall,
  output tlvc_pkg::result_t                 result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tlvc_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [tlvc_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [tlvc_pkg::PDATA_BITS-1:0]   prdata,
  output logic                              pready
);

  localparam int CALC       = tlvc_pkg::CALC_BITS;
  localparam int DRAIN_LAST = 2;
  localparam int CMP_BITS   = (tlvc_pkg::DIV_BITS > tlvc_pkg::VAR_BITS) ?
                              tlvc_pkg::DIV_BITS : tlvc_pkg::VAR_BITS + 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WALK   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t                                state;
  state_t                                state_next;
  logic [tlvc_pkg::MAP_SIDE_BITS-1:0]    map_side;
  logic [tlvc_pkg::LIMIT_BITS-1:0]       smooth_limit;
  logic [tlvc_pkg::LIMIT_BITS-1:0]       rough_limit;
  logic [tlvc_pkg::POS_BITS-1:0]         cx;
  logic [tlvc_pkg::POS_BITS-1:0]         cy;
  logic [tlvc_pkg::SAMPLE_BITS-1:0]      ref_h;
  logic [tlvc_pkg::WIN_BITS-1:0]         wx;
  logic [tlvc_pkg::WIN_BITS-1:0]         wy;
  logic [1:0]                            drain_cnt;
  logic                                  div_start;
  logic                                  take_q;

  logic                                  req_accept;
  logic                                  query_accept;
  logic                                  cfg_write;
  logic                                  walk_last;
  logic                                  result_load;
  logic [CALC-1:0]                       side_ext;
  logic [CALC-1:0]                       side_use;
  logic [CALC-1:0]                       clamp_hi;
  logic [CALC-1:0]                       rx;
  logic [CALC-1:0]                       ry;
  logic                                  skip;
  logic [CALC-1:0]                       wr_x;
  logic [CALC-1:0]                       wr_y;
  logic                                  mem_en;
  logic                                  mem_we;
  logic [tlvc_pkg::ADDR_BITS-1:0]        mem_addr;
  logic [tlvc_pkg::SAMPLE_BITS-1:0]      mem_rdata;
  tlvc_pkg::acc_ctl_t                    acc_ctl;
  logic [tlvc_pkg::SUM_BITS-1:0]         acc_sum;
  tlvc_pkg::div_stat_t                   div_stat;
  logic [tlvc_pkg::DIV_BITS-1:0]         div_quot;
  logic [tlvc_pkg::REM_BITS-1:0]         div_rem;
  logic [CMP_BITS-1:0]                   q_cmp;
  logic                                  smooth_ok;
  logic                                  rough_ok;
  tlvc_pkg::terrain_class_t              class_sel;
  logic [tlvc_pkg::VAR_BITS-1:0]         var_sat;

  // Clamp a signed window coordinate to 0 .. hi.
  function automatic logic [CALC-1:0] clamp_coord(input logic [CALC-1:0] v,
                                                  input logic [CALC-1:0] hi);
    logic [CALC-1:0] r;
    if (v[CALC-1]) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Handshakes.
  assign request_stall = (state != ST_IDLE);
  assign req_accept    = request_valid && !request_stall;
  assign query_accept  = req_accept && (request.action == tlvc_pkg::ACT_QUERY);
  assign pready        = 1'b1;
  assign cfg_write     = psel && penable && pwrite && pready;
  assign result_load   = (state == ST_FINISH) && (!result_valid || !result_stall);

  // Side in use and the clamp bound.
  assign side_ext = CALC'(map_side);
  always_comb begin
    if (side_ext == '0) begin
      side_use = CALC'(1);
    end else if (side_ext > CALC'(tlvc_pkg::MAX_SIDE)) begin
      side_use = CALC'(tlvc_pkg::MAX_SIDE);
    end else begin
      side_use = side_ext;
    end
  end
  assign clamp_hi = side_use - CALC'(1);

  // Current window position and the centre skip.
  assign rx   = clamp_coord(CALC'(cx) + CALC'(wx) - CALC'(tlvc_pkg::WIN_RADIUS), clamp_hi);
  assign ry   = clamp_coord(CALC'(cy) + CALC'(wy) - CALC'(tlvc_pkg::WIN_RADIUS), clamp_hi);
  assign skip = (rx == CALC'(cx)) && (ry == CALC'(cy));
  assign walk_last = (wx == tlvc_pkg::WIN_BITS'(tlvc_pkg::WIN_LAST)) &&
                     (wy == tlvc_pkg::WIN_BITS'(tlvc_pkg::WIN_LAST));

  // Store port: a write request writes at acceptance, the walk reads.
  assign wr_x   = CALC'(request.pos_x);
  assign wr_y   = CALC'(request.pos_y);
  assign mem_we = req_accept && (request.action == tlvc_pkg::ACT_WRITE) &&
                  (wr_x < CALC'(tlvc_pkg::MAX_SIDE)) && (wr_y < CALC'(tlvc_pkg::MAX_SIDE));
  assign mem_en = mem_we || (state == ST_WALK);
  always_comb begin
    if (mem_we) begin
      mem_addr = {wr_y[tlvc_pkg::COORD_BITS-1:0], wr_x[tlvc_pkg::COORD_BITS-1:0]};
    end else begin
      mem_addr = {ry[tlvc_pkg::COORD_BITS-1:0], rx[tlvc_pkg::COORD_BITS-1:0]};
    end
  end

  tlvc_store u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (tlvc_pkg::SAMPLE_BITS'(request.height_value)),
    .rdata (mem_rdata)
  );

  // Square-accumulate: take marks read data that belongs to the sum.
  assign acc_ctl.clear = query_accept;
  assign acc_ctl.take  = take_q;

  tlvc_sqacc u_sqacc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (acc_ctl),
    .ref_height (ref_h),
    .sample     (mem_rdata),
    .sum        (acc_sum)
  );

  tlvc_div24 u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (acc_sum),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Classification: sum <= 24*limit holds when q < limit, or q == limit
  // with no remainder.
  assign q_cmp     = CMP_BITS'(div_quot);
  assign smooth_ok = (q_cmp < CMP_BITS'(smooth_limit)) ||
                     ((q_cmp == CMP_BITS'(smooth_limit)) && (div_rem == '0));
  assign rough_ok  = (q_cmp < CMP_BITS'(rough_limit)) ||
                     ((q_cmp == CMP_BITS'(rough_limit)) && (div_rem == '0));
  always_comb begin
    if (smooth_ok) begin
      class_sel = tlvc_pkg::CLASS_SMOOTH;
    end else if (rough_ok) begin
      class_sel = tlvc_pkg::CLASS_ROUGH;
    end else begin
      class_sel = tlvc_pkg::CLASS_SHARP;
    end
  end
  assign var_sat = (q_cmp > CMP_BITS'({tlvc_pkg::VAR_BITS{1'b1}})) ?
                   {tlvc_pkg::VAR_BITS{1'b1}} : tlvc_pkg::VAR_BITS'(q_cmp);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (query_accept) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == 2'(DRAIN_LAST)) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!div_start && div_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (result_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer, window counters and handshake state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wx           <= '0;
      wy           <= '0;
      drain_cnt    <= '0;
      div_start    <= 1'b0;
      take_q       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state     <= state_next;
      take_q    <= (state == ST_WALK) && !skip;
      div_start <= (state == ST_DRAIN) && (drain_cnt == 2'(DRAIN_LAST));
      if (query_accept) begin
        wx <= '0;
        wy <= '0;
      end else if (state == ST_WALK) begin
        if (wx == tlvc_pkg::WIN_BITS'(tlvc_pkg::WIN_LAST)) begin
          wx <= '0;
          wy <= wy + 1'b1;
        end else begin
          wx <= wx + 1'b1;
        end
      end
      if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt + 1'b1;
      end else begin
        drain_cnt <= '0;
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Query operands and the result payload.
  always_ff @(posedge clk) begin
    if (query_accept) begin
      cx    <= request.pos_x;
      cy    <= request.pos_y;
      ref_h <= tlvc_pkg::SAMPLE_BITS'(request.height_value);
    end
    if (result_load) begin
      result.terrain_class <= class_sel;
      result.variance      <= var_sat;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_side     <= tlvc_pkg::MAP_SIDE_BITS'(256);
      smooth_limit <= tlvc_pkg::LIMIT_BITS'(1);
      rough_limit  <= tlvc_pkg::LIMIT_BITS'(4);
    end else if (cfg_write) begin
      unique case (tlvc_pkg::reg_index_t'(paddr[tlvc_pkg::PADDR_BITS-1:2]))
        tlvc_pkg::REG_MAP_SIDE:     map_side     <= pwdata[tlvc_pkg::MAP_SIDE_BITS-1:0];
        tlvc_pkg::REG_SMOOTH_LIMIT: smooth_limit <= pwdata[tlvc_pkg::LIMIT_BITS-1:0];
        tlvc_pkg::REG_ROUGH_LIMIT:  rough_limit  <= pwdata[tlvc_pkg::LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (tlvc_pkg::reg_index_t'(paddr[tlvc_pkg::PADDR_BITS-1:2]))
      tlvc_pkg::REG_MAP_SIDE:     prdata = tlvc_pkg::PDATA_BITS'(map_side);
      tlvc_pkg::REG_SMOOTH_LIMIT: prdata = tlvc_pkg::PDATA_BITS'(smooth_limit);
      tlvc_pkg::REG_ROUGH_LIMIT:  prdata = tlvc_pkg::PDATA_BITS'(rough_limit);
      default:                    prdata = '0;
    endcase
  end

  // A query request starts the window walk on the next cycle.
  `TLVC_ASSERT_NEXT(a_query_starts_walk, query_accept, state == ST_WALK)
  // A finished query is presented once the output register is free.
  `TLVC_ASSERT_NEXT(a_finish_presents, (state == ST_FINISH) && !(result_valid && result_stall), result_valid)
  // The divider only runs while the sequencer waits for it.
  `TLVC_ASSERT_NOW(a_div_in_divide, div_stat.busy, state == ST_DIVIDE)

endmodule
`default_nettype wire
